### rtl/uvt_pkg.sv
// ----------------------------------------------------------------------------
// uvt_pkg
// Shared types and constants for the unique value table: request and
// response payloads, status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package uvt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int ECOUNT_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [ECOUNT_W-1:0]   entry_count;
  } rsp_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic                       go;       // request accepted this cycle
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
    logic                       present;  // some occupied cell matched
    logic [CNT_W-1:0]           count;    // current number of entries
  } cell_ctrl_t;

endpackage

### rtl/unique_value_table.sv
// ----------------------------------------------------------------------------
// unique_value_table
// Bounded table of distinct signed 32-bit values kept in insertion order,
// built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Response: registered, valid in the cycle after the request is accepted.
// Throughput: one request per cycle while rsp_ready keeps the output free;
//   the match and hit chain across the CAPACITY cells are combinational.
// Reset: rst (synchronous, active high) clears the entry count and the
//   response valid flag; cell contents are left as they are and only slots
//   below the count are ever compared.
module unique_value_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  uvt_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output uvt_pkg::rsp_t  rsp
);

  localparam int N = uvt_pkg::CAPACITY;

  logic [uvt_pkg::CNT_W-1:0]          count;
  logic [uvt_pkg::CNT_W-1:0]          count_next;
  uvt_pkg::status_t                   status_next;
  uvt_pkg::cell_ctrl_t                ctrl;
  logic                               go;
  logic                               full;
  logic [N:0]                         hit;
  logic [N-1:0]                       match;
  logic signed [uvt_pkg::VALUE_W-1:0] ent [N];

  // Output register decouples the two sides: a new request is taken
  // whenever the held response is empty or leaving this cycle.
  assign req_ready = !rsp_valid || rsp_ready;
  assign go        = req_valid && req_ready;
  assign full      = count == uvt_pkg::CNT_W'(N);

  // Hit chain runs from slot 0 upward, so hit[i+1] marks the first
  // match at or below slot i; hit[N] says the value is present.
  assign hit[0] = 1'b0;

  always_comb begin
    ctrl.go      = go;
    ctrl.op      = req.op;
    ctrl.value   = req.value;
    ctrl.present = hit[N];
    ctrl.count   = count;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [uvt_pkg::VALUE_W-1:0] nbr;
    if (i == N - 1) begin : g_last
      assign nbr = '0;  // top slot empties on remove; count hides it
    end else begin : g_mid
      assign nbr = ent[i+1];
    end

    uvt_cell u_cell (
      .clk       (clk),
      .index     (uvt_pkg::IDX_W'(i)),
      .ctrl      (ctrl),
      .hit_in    (hit[i]),
      .nbr_entry (nbr),
      .entry     (ent[i]),
      .match     (match[i]),
      .hit_out   (hit[i+1])
    );
  end

  // Status and new count. Presence is checked before fullness, so a
  // present value in a full table reports as already present.
  always_comb begin
    count_next  = count;
    status_next = uvt_pkg::ST_NOT_FOUND;
    case (req.op)
      uvt_pkg::OP_INSERT: begin
        if (hit[N]) begin
          status_next = uvt_pkg::ST_PRESENT;
        end else if (full) begin
          status_next = uvt_pkg::ST_FULL;
        end else begin
          status_next = uvt_pkg::ST_INSERTED;
          count_next  = count + uvt_pkg::CNT_W'(1);
        end
      end
      uvt_pkg::OP_REMOVE: begin
        if (hit[N]) begin
          status_next = uvt_pkg::ST_REMOVED;
          count_next  = count - uvt_pkg::CNT_W'(1);
        end else begin
          status_next = uvt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = uvt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (go) begin
      rsp.status      <= status_next;
      rsp.entry_count <= uvt_pkg::ECOUNT_W'(count_next);
    end
  end

`ifndef SYNTHESIS
  // Count never runs past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= uvt_pkg::CNT_W'(N))
    else $error("entry count exceeds capacity");

  // Stored values are distinct, so at most one occupied cell matches.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("more than one cell matched");

  // A successful insert grows the table by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    go && (req.op == uvt_pkg::OP_INSERT) && !hit[N] && !full
    |=> count == $past(count) + uvt_pkg::CNT_W'(1))
    else $error("insert did not advance the count");

  // A remove of a present value shrinks the table by exactly one.
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    go && (req.op == uvt_pkg::OP_REMOVE) && hit[N]
    |=> count == $past(count) - uvt_pkg::CNT_W'(1))
    else $error("remove did not reduce the count");
`endif

endmodule

### rtl/uvt_cell.sv
// ----------------------------------------------------------------------------
// uvt_cell
// One table slot: holds an entry, compares it with the broadcast value,
// passes the hit chain on, takes a new value on an insert at the tail,
// and takes its upper neighbor's entry on a remove at or below it.
// ----------------------------------------------------------------------------
module uvt_cell (
  input  logic                               clk,
  input  logic [uvt_pkg::IDX_W-1:0]          index,
  input  uvt_pkg::cell_ctrl_t                ctrl,
  input  logic                               hit_in,
  input  logic signed [uvt_pkg::VALUE_W-1:0] nbr_entry,
  output logic signed [uvt_pkg::VALUE_W-1:0] entry,
  output logic                               match,
  output logic                               hit_out
);

  logic occupied;
  logic at_tail;
  logic do_shift;
  logic do_write;

  assign occupied = uvt_pkg::CNT_W'(index) < ctrl.count;
  assign at_tail  = uvt_pkg::CNT_W'(index) == ctrl.count;
  assign match    = occupied && (entry == ctrl.value);
  assign hit_out  = hit_in || match;

  // Cells from the first match upward pull their neighbor's entry down.
  assign do_shift = ctrl.go && (ctrl.op == uvt_pkg::OP_REMOVE) && hit_out;
  // First free slot takes a new value; a full table has no such slot.
  assign do_write = ctrl.go && (ctrl.op == uvt_pkg::OP_INSERT) && at_tail &&
                    !ctrl.present;

  always_ff @(posedge clk) begin
    if (do_write) begin
      entry <= ctrl.value;
    end else if (do_shift) begin
      entry <= nbr_entry;
    end
  end

endmodule
